[src/twbfs_pkg.sv]
`timescale 1ns / 1ps

package twbfs_pkg;

    localparam int unsigned FREQ_IN_W  = 27;
    localparam int unsigned OFFSET_W   = 18;
    localparam int unsigned FREQ_W     = 28;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned ATTEN_W    = 5;
    localparam int unsigned ANT_W      = 3;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 18;

    localparam logic [63:0] CLOCK_HZ = 64'd122880000;

    // Reciprocal of the sample clock: M = floor(2^(32+S) / CLOCK_HZ), S fraction bits.
    // Since f < 2^S the estimate is low by at most one.
    localparam int unsigned RECIP_SHIFT = FREQ_W;
    localparam logic [63:0] PHASE_RECIP = (64'd1 << (32 + RECIP_SHIFT)) / CLOCK_HZ;
    localparam int unsigned RECIP_LO_W  = 20;
    localparam int unsigned RECIP_HI_W  = 21;
    localparam int unsigned QEST_W      = RECIP_LO_W + RECIP_HI_W;
    localparam int unsigned PLO_W       = FREQ_W + RECIP_LO_W;
    localparam int unsigned PHI_W       = FREQ_W + RECIP_HI_W;
    localparam int unsigned SUM_W       = FREQ_W + QEST_W;

    localparam logic [RECIP_LO_W-1:0] RECIP_LO = PHASE_RECIP[RECIP_LO_W-1:0];
    localparam logic [RECIP_HI_W-1:0] RECIP_HI =
        PHASE_RECIP[RECIP_LO_W+RECIP_HI_W-1:RECIP_LO_W];
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (RECIP_SHIFT - 1);

    localparam logic [WORD_W-1:0] CLK_W32  = CLOCK_HZ[WORD_W-1:0];
    localparam logic [63:0]       CLK_X2   = CLOCK_HZ * 64'd2;
    localparam logic [WORD_W-1:0] CLK2_W32 = CLK_X2[WORD_W-1:0];

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_OFFSET = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANTENNA     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_PA      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEN       = 4'd3;

    // Antenna codes
    localparam logic [ANT_W-1:0] ANT_1   = 3'd0;
    localparam logic [ANT_W-1:0] ANT_2   = 3'd1;
    localparam logic [ANT_W-1:0] ANT_3   = 3'd2;
    localparam logic [ANT_W-1:0] ANT_EX1 = 3'd3;
    localparam logic [ANT_W-1:0] ANT_EX2 = 3'd4;
    localparam logic [ANT_W-1:0] ANT_XVT = 3'd5;

    // High-pass thresholds and bits
    localparam logic [FREQ_IN_W-1:0] HPF_T0 = 27'd1800000;
    localparam logic [FREQ_IN_W-1:0] HPF_T1 = 27'd6500000;
    localparam logic [FREQ_IN_W-1:0] HPF_T2 = 27'd9500000;
    localparam logic [FREQ_IN_W-1:0] HPF_T3 = 27'd13000000;
    localparam logic [FREQ_IN_W-1:0] HPF_T4 = 27'd20000000;
    localparam logic [FREQ_IN_W-1:0] HPF_T5 = 27'd50000000;

    localparam logic [WORD_W-1:0] HPF_BYP   = 32'h0000_1000;
    localparam logic [WORD_W-1:0] HPF_1M5   = 32'h0000_0040;
    localparam logic [WORD_W-1:0] HPF_6M5   = 32'h0000_0020;
    localparam logic [WORD_W-1:0] HPF_9M5   = 32'h0000_0010;
    localparam logic [WORD_W-1:0] HPF_13M   = 32'h0000_0002;
    localparam logic [WORD_W-1:0] HPF_20M   = 32'h0000_0004;
    localparam logic [WORD_W-1:0] HPF_PRE   = 32'h0000_0008;

    // Low-pass thresholds and bits
    localparam logic [FREQ_IN_W-1:0] LPF_RXONLY_HZ = 27'd40000000;
    localparam logic [FREQ_IN_W-1:0] LPF_T0 = 27'd35600000;
    localparam logic [FREQ_IN_W-1:0] LPF_T1 = 27'd24000000;
    localparam logic [FREQ_IN_W-1:0] LPF_T2 = 27'd16500000;
    localparam logic [FREQ_IN_W-1:0] LPF_T3 = 27'd8000000;
    localparam logic [FREQ_IN_W-1:0] LPF_T4 = 27'd5000000;
    localparam logic [FREQ_IN_W-1:0] LPF_T5 = 27'd2500000;

    localparam logic [WORD_W-1:0] LPF_6M    = 32'h2000_0000;
    localparam logic [WORD_W-1:0] LPF_10M   = 32'h4000_0000;
    localparam logic [WORD_W-1:0] LPF_15M   = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LPF_20M   = 32'h0010_0000;
    localparam logic [WORD_W-1:0] LPF_40M   = 32'h0020_0000;
    localparam logic [WORD_W-1:0] LPF_80M   = 32'h0040_0000;
    localparam logic [WORD_W-1:0] LPF_160M  = 32'h0080_0000;

    // Antenna routing bits
    localparam logic [WORD_W-1:0] RT_ANT1   = 32'h0100_0000;
    localparam logic [WORD_W-1:0] RT_ANT2   = 32'h0200_0000;
    localparam logic [WORD_W-1:0] RT_ANT3   = 32'h0400_0000;
    localparam logic [WORD_W-1:0] RT_EX1    = 32'h0000_0200;
    localparam logic [WORD_W-1:0] RT_EX2    = 32'h0000_0400;
    localparam logic [WORD_W-1:0] RT_XVT    = 32'h0000_0100;
    localparam logic [WORD_W-1:0] RT_BYPASS = 32'h0000_0800;

    typedef struct packed {
        logic st2;
        logic st3;
        logic st4;
    } lane_en_t;

    typedef struct packed {
        logic [WORD_W-1:0] rx;
        logic [WORD_W-1:0] tx;
    } filter_words_t;

    typedef struct packed {
        logic [WORD_W-1:0]  seq;
        filter_words_t      words;
        logic [ATTEN_W-1:0] atten;
    } item_meta_t;

endpackage

[src/twbfs_filter_sel.sv]
`timescale 1ns / 1ps

module twbfs_filter_sel
(
    input  logic [twbfs_pkg::FREQ_IN_W-1:0] freq_hz,
    input  logic [twbfs_pkg::ANT_W-1:0]     antenna,
    input  logic                            new_pa,
    output twbfs_pkg::filter_words_t        words
);
    import twbfs_pkg::*;

    logic                 main_ant;
    logic [FREQ_IN_W-1:0] lpf_freq;
    logic [WORD_W-1:0]    hpf_bits;
    logic [WORD_W-1:0]    lpf_bits;
    logic [WORD_W-1:0]    route_bits;

    assign main_ant = (antenna == ANT_1) || (antenna == ANT_2) || (antenna == ANT_3);
    assign lpf_freq = main_ant ? freq_hz : LPF_RXONLY_HZ;

    always_comb
    begin
        priority if (freq_hz < HPF_T0) hpf_bits = HPF_BYP;
        else if (freq_hz < HPF_T1)     hpf_bits = HPF_1M5;
        else if (freq_hz < HPF_T2)     hpf_bits = HPF_6M5;
        else if (freq_hz < HPF_T3)     hpf_bits = HPF_9M5;
        else if (freq_hz < HPF_T4)     hpf_bits = HPF_13M;
        else if (freq_hz < HPF_T5)     hpf_bits = HPF_20M;
        else                           hpf_bits = HPF_PRE;
    end

    always_comb
    begin
        priority if (lpf_freq > LPF_T0) lpf_bits = LPF_6M;
        else if (lpf_freq > LPF_T1)     lpf_bits = LPF_10M;
        else if (lpf_freq > LPF_T2)     lpf_bits = LPF_15M;
        else if (lpf_freq > LPF_T3)     lpf_bits = LPF_20M;
        else if (lpf_freq > LPF_T4)     lpf_bits = LPF_40M;
        else if (lpf_freq > LPF_T5)     lpf_bits = LPF_80M;
        else                            lpf_bits = LPF_160M;
    end

    // codes 6 and 7 behave as receive-only inputs with no extra routing bit beyond RT_ANT1 and RT_BYPASS
    always_comb
    begin
        unique case (antenna)
            ANT_2:   route_bits = RT_ANT2;
            ANT_3:   route_bits = RT_ANT3;
            ANT_EX1: route_bits = RT_ANT1 | RT_EX1;
            ANT_EX2: route_bits = RT_ANT1 | RT_EX2;
            ANT_XVT: route_bits = RT_ANT1 | RT_XVT;
            default: route_bits = RT_ANT1;
        endcase
        if (!main_ant && !new_pa)
        begin
            route_bits = route_bits | RT_BYPASS;
        end
    end

    assign words.rx = hpf_bits | lpf_bits | route_bits;
    assign words.tx = lpf_bits | RT_ANT1;

endmodule

[src/twbfs_phase_lane.sv]
`timescale 1ns / 1ps

module twbfs_phase_lane
(
    input  logic                         clk,
    input  twbfs_pkg::lane_en_t          en,
    input  logic [twbfs_pkg::FREQ_W-1:0] freq,
    output logic [twbfs_pkg::WORD_W-1:0] phase_inc
);
    import twbfs_pkg::*;

    logic [PLO_W-1:0]  plo_reg;
    logic [PHI_W-1:0]  phi_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [QEST_W-1:0] qest_reg;
    logic [QEST_W-1:0] qfin_reg;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W:0]   q_inc;

    // estimate = floor(f*M / 2^S + 1/2), low by at most one
    assign sum_next = SUM_W'(plo_reg) + (SUM_W'(phi_reg) << RECIP_LO_W) + ROUND_HALF;

    // remainder of 2^33 f + CLOCK_HZ - 2 CLOCK_HZ q, taken modulo 2^32
    assign rem_next = CLK_W32 - (qest_reg[WORD_W-1:0] * CLK2_W32);

    always_ff @(posedge clk)
    begin
        if (en.st2)
        begin
            plo_reg <= PLO_W'(freq) * PLO_W'(RECIP_LO);
            phi_reg <= PHI_W'(freq) * PHI_W'(RECIP_HI);
        end
        if (en.st3)
        begin
            qest_reg <= sum_next[SUM_W-1:RECIP_SHIFT];
        end
        if (en.st4)
        begin
            qfin_reg <= qest_reg;
            rem_reg  <= rem_next;
        end
    end

    assign q_inc = {1'b0, qfin_reg[WORD_W-1:0]} + (WORD_W+1)'(1);

    always_comb
    begin
        priority if (qfin_reg[QEST_W-1:WORD_W] != '0) phase_inc = '1;
        else if (rem_reg >= CLK2_W32)
        begin
            phase_inc = q_inc[WORD_W] ? '1 : q_inc[WORD_W-1:0];
        end
        else phase_inc = qfin_reg[WORD_W-1:0];
    end

endmodule

[src/tuning_word_and_band_filter_select.sv]
`timescale 1ns / 1ps

// Tuning word and band filter select.
// Input channel (in_valid/in_ready) carries two tuning frequencies in Hz; each
// transaction yields exactly one result on the output channel (out_valid/out_ready):
// sequence number, two NCO phase increments, receive and transmit filter words and
// the attenuator setting.
// Configuration channel (cfg_valid/cfg_ready) writes offset, antenna, PA board
// and attenuator by cfg_index; cfg_ready is always high.
// The two frequencies run through two identical phase lanes (reciprocal
// multiply split in two partial products, sum, remainder check, rounding fix);
// results merge with the filter words in the output register.
// Pipeline: input register, partial products, estimate, remainder, output register.
// Throughput: one transaction per cycle unless out_ready stalls the five-stage
// pipeline. Stalls on out_ready hold the output register and fill empty stages
// upstream before in_ready drops.
// Reset clears the registers to offset 0, antenna 1, new PA board, 0 dB, the
// sequence count to 0 and empties the pipeline.

module tuning_word_and_band_filter_select
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [twbfs_pkg::FREQ_IN_W-1:0]   freq_a_hz,
    input  logic [twbfs_pkg::FREQ_IN_W-1:0]   freq_b_hz,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [twbfs_pkg::WORD_W-1:0]      seq_number,
    output logic [twbfs_pkg::WORD_W-1:0]      phase_inc_a,
    output logic [twbfs_pkg::WORD_W-1:0]      phase_inc_b,
    output logic [twbfs_pkg::WORD_W-1:0]      filter_word_rx,
    output logic [twbfs_pkg::WORD_W-1:0]      filter_word_tx,
    output logic [twbfs_pkg::ATTEN_W-1:0]     atten_out,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [twbfs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [twbfs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import twbfs_pkg::*;

    logic [OFFSET_W-1:0] offset_reg;
    logic [ANT_W-1:0]    antenna_reg;
    logic                new_pa_reg;
    logic [ATTEN_W-1:0]  atten_reg;
    logic [WORD_W-1:0]   seq_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic en1, en2, en3, en4, en_out;
    lane_en_t lane_en;

    logic [FREQ_W-1:0] fa_reg, fb_reg;
    logic [FREQ_W-1:0] fa_next, fb_next;
    item_meta_t        meta1_reg, meta2_reg, meta3_reg, meta4_reg;
    item_meta_t        meta_out_reg;
    filter_words_t     words_next;
    logic [WORD_W-1:0] pa_lane, pb_lane;
    logic [WORD_W-1:0] pa_reg, pb_reg;

    logic signed [FREQ_W:0] sum_a, sum_b;

    assign cfg_ready = 1'b1;

    // stall chain: a stage loads when empty or when the next one loads
    assign en_out   = !out_valid_reg || out_ready;
    assign en4      = !v4_reg || en_out;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign lane_en.st2 = en2;
    assign lane_en.st3 = en3;
    assign lane_en.st4 = en4;

    // offset added, negative sums clamped to zero
    assign sum_a   = $signed({2'b00, freq_a_hz}) + (FREQ_W+1)'($signed(offset_reg));
    assign sum_b   = $signed({2'b00, freq_b_hz}) + (FREQ_W+1)'($signed(offset_reg));
    assign fa_next = sum_a[FREQ_W] ? '0 : sum_a[FREQ_W-1:0];
    assign fb_next = sum_b[FREQ_W] ? '0 : sum_b[FREQ_W-1:0];

    twbfs_filter_sel u_filter
    (
        .freq_hz (freq_a_hz),
        .antenna (antenna_reg),
        .new_pa  (new_pa_reg),
        .words   (words_next)
    );

    twbfs_phase_lane u_lane_a
    (
        .clk       (clk),
        .en        (lane_en),
        .freq      (fa_reg),
        .phase_inc (pa_lane)
    );

    twbfs_phase_lane u_lane_b
    (
        .clk       (clk),
        .en        (lane_en),
        .freq      (fb_reg),
        .phase_inc (pb_lane)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            antenna_reg   <= ANT_1;
            new_pa_reg    <= 1'b1;
            atten_reg     <= '0;
            seq_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_FREQ_OFFSET: offset_reg  <= cfg_data;
                    CFG_ANTENNA:     antenna_reg <= cfg_data[ANT_W-1:0];
                    CFG_NEW_PA:      new_pa_reg  <= cfg_data[0];
                    CFG_ATTEN:       atten_reg   <= cfg_data[ATTEN_W-1:0];
                    default:         ;
                endcase
            end
            if (in_valid && en1)
            begin
                seq_reg <= seq_reg + WORD_W'(1);
            end
            if (en1)    v1_reg        <= in_valid;
            if (en2)    v2_reg        <= v1_reg;
            if (en3)    v3_reg        <= v2_reg;
            if (en4)    v4_reg        <= v3_reg;
            if (en_out) out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            fa_reg          <= fa_next;
            fb_reg          <= fb_next;
            meta1_reg.seq   <= seq_reg;
            meta1_reg.words <= words_next;
            meta1_reg.atten <= atten_reg;
        end
        if (en2)    meta2_reg <= meta1_reg;
        if (en3)    meta3_reg <= meta2_reg;
        if (en4)    meta4_reg <= meta3_reg;
        if (en_out)
        begin
            meta_out_reg <= meta4_reg;
            pa_reg       <= pa_lane;
            pb_reg       <= pb_lane;
        end
    end

    assign out_valid      = out_valid_reg;
    assign seq_number     = meta_out_reg.seq;
    assign phase_inc_a    = pa_reg;
    assign phase_inc_b    = pb_reg;
    assign filter_word_rx = meta_out_reg.words.rx;
    assign filter_word_tx = meta_out_reg.words.tx;
    assign atten_out      = meta_out_reg.atten;

endmodule
